// ----- sv/dpbc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpbc_pkg
// Shared widths, register indexes, reset values and types of the dual PID
// balance controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpbc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ERR_W    = 17;
	localparam int DIFF_W   = 18;
	localparam int GAIN_W   = 32;
	localparam int SUM_W    = 32;
	localparam int FRAC_SH  = 20;
	localparam int DRIVE_W  = 16;

	localparam int P_PROD_W = GAIN_W + ERR_W;
	localparam int I_PROD_W = GAIN_W + SUM_W;
	localparam int D_PROD_W = GAIN_W + DIFF_W;
	localparam int P_TERM_W = P_PROD_W - FRAC_SH;
	localparam int I_TERM_W = I_PROD_W - FRAC_SH;
	localparam int D_TERM_W = D_PROD_W - FRAC_SH;
	localparam int LANE_W   = I_TERM_W + 2;
	localparam int TOTAL_W  = LANE_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SETPOINT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CART_SETPOINT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KI       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CART_KP        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CART_KI        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CART_KD        = 3'd7;

	// reset gains, Q12.20
	localparam logic signed [GAIN_W-1:0] ANGLE_KP_RST = 32'sd20971520;
	localparam logic signed [GAIN_W-1:0] ANGLE_KI_RST = 32'sd146801;
	localparam logic signed [GAIN_W-1:0] ANGLE_KD_RST = 32'sd10485760;
	localparam logic signed [GAIN_W-1:0] CART_KP_RST  = -32'sd209715;
	localparam logic signed [GAIN_W-1:0] CART_KI_RST  = -32'sd210;
	localparam logic signed [GAIN_W-1:0] CART_KD_RST  = -32'sd52429;

	// |angle error| above 10.0 in Q8.8 bypasses the PID
	localparam logic signed [ERR_W-1:0] SWING_THRESHOLD = 17'sd2560;

	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7fff;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -16'sh8000;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic move12;  // operands enter stage 2, state updates
		logic move23;  // products enter stage 3
		logic swing;   // item in stage 1 is in swing-up
	} lane_ctrl_t;

endpackage

// ----- sv/dpbc_lane.sv -----
// ----------------------------------------------------------------------------
// dpbc_lane
// One PID lane: error, saturating integrator, derivative, three products
// floored to Q8.8 and their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpbc_lane
	import dpbc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] setpoint,
	input  logic signed [SAMPLE_W-1:0] sample_s1,
	input  gains_t                     gains,
	output logic signed [ERR_W-1:0]    err,
	output logic signed [LANE_W-1:0]   term_sum
);

	logic signed [SUM_W-1:0]    sum_q;
	logic signed [ERR_W-1:0]    prev_q;
	logic signed [SUM_W:0]      sum_raw;
	logic signed [SUM_W-1:0]    sum_next;

	logic signed [ERR_W-1:0]    err_s2;
	logic signed [SUM_W-1:0]    sum_s2;
	logic signed [DIFF_W-1:0]   diff_s2;

	logic signed [P_PROD_W-1:0] p_prod;
	logic signed [I_PROD_W-1:0] i_prod;
	logic signed [D_PROD_W-1:0] d_prod;

	logic signed [P_TERM_W-1:0] p_term_s3;
	logic signed [I_TERM_W-1:0] i_term_s3;
	logic signed [D_TERM_W-1:0] d_term_s3;

	assign err = ERR_W'(setpoint) - ERR_W'(sample_s1);

	// saturate integrator to 32 bits
	assign sum_raw = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err);
	always_comb begin
		if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
			sum_next = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
			                          : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_raw[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctrl.move12) begin
			if (ctrl.swing) begin
				sum_q  <= '0;
				prev_q <= '0;
			end else begin
				sum_q  <= sum_next;
				prev_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.move12) begin
			err_s2  <= err;
			sum_s2  <= sum_next;
			diff_s2 <= DIFF_W'(err) - DIFF_W'(prev_q);
		end
	end

	assign p_prod = P_PROD_W'(gains.kp) * P_PROD_W'(err_s2);
	assign i_prod = I_PROD_W'(gains.ki) * I_PROD_W'(sum_s2);
	assign d_prod = D_PROD_W'(gains.kd) * D_PROD_W'(diff_s2);

	// dropping the low 20 bits of a two's complement product floors it
	always_ff @(posedge clk) begin
		if (ctrl.move23) begin
			p_term_s3 <= p_prod[P_PROD_W-1:FRAC_SH];
			i_term_s3 <= i_prod[I_PROD_W-1:FRAC_SH];
			d_term_s3 <= d_prod[D_PROD_W-1:FRAC_SH];
		end
	end

	assign term_sum = LANE_W'(p_term_s3) + LANE_W'(i_term_s3) + LANE_W'(d_term_s3);

	a_swing_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.move12 && ctrl.swing |=> sum_q == '0 && prev_q == '0)
		else $error("swing-up did not clear lane state");

	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.move12 && !ctrl.swing |=> prev_q == $past(err))
		else $error("previous error not captured");

	a_operands_match: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.move12 && !ctrl.swing |=> sum_s2 == sum_q && err_s2 == prev_q)
		else $error("stage 2 operands disagree with lane state");

endmodule

// ----- sv/dual_pid_balance_controller.sv -----
// Path: an accepted item passes the input, operand and product stages, then is offered on m_tvalid.
// Throughput: one item per cycle while m_tready does not stall the output; four register stages
// (input, operands, products, output) each move whenever the stage after them is empty or moving.
// The integrator/previous-error update sits in the operand stage and is made as the item moves into it.
// Reset: asynchronous, active low; clears integrators, previous errors, stage valid
// bits and restores all configuration registers to their defaults.
// ----------------------------------------------------------------------------
// dual_pid_balance_controller
// Two summed PID loops (pendulum angle, cart position) with swing-up bypass
// and 16-bit saturated drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_pid_balance_controller
	import dpbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] angle_sample, [31:16] cart_sample

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] drive, [32:16] angle_error,
	                                          // [49:33] cart_error, [55:50] zero
	output logic                  m_tuser,   // [0] swing_up

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [SAMPLE_W-1:0] angle_sp_q, cart_sp_q;
	gains_t                     angle_gains_q, cart_gains_q;

	logic                       valid_s1, valid_s2, valid_s3, m_valid_q;
	logic                       move12, move23, move3o;
	logic signed [SAMPLE_W-1:0] angle_s1, cart_s1;

	logic signed [ERR_W-1:0]    aerr, cerr;
	logic                       swing;
	logic signed [ERR_W-1:0]    aerr_s2, cerr_s2, aerr_s3, cerr_s3;
	logic                       swing_s2, swing_s3;
	lane_ctrl_t                 ctrl;
	logic signed [LANE_W-1:0]   angle_term, cart_term;
	logic signed [TOTAL_W-1:0]  total;
	logic signed [DRIVE_W-1:0]  drive_sat;

	logic signed [DRIVE_W-1:0]  drive_q;
	logic                       swing_q;
	logic signed [ERR_W-1:0]    aerr_q, cerr_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_sp_q       <= '0;
			cart_sp_q        <= '0;
			angle_gains_q.kp <= ANGLE_KP_RST;
			angle_gains_q.ki <= ANGLE_KI_RST;
			angle_gains_q.kd <= ANGLE_KD_RST;
			cart_gains_q.kp  <= CART_KP_RST;
			cart_gains_q.ki  <= CART_KI_RST;
			cart_gains_q.kd  <= CART_KD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ANGLE_SETPOINT: angle_sp_q       <= cfg_data[SAMPLE_W-1:0];
				REG_CART_SETPOINT:  cart_sp_q        <= cfg_data[SAMPLE_W-1:0];
				REG_ANGLE_KP:       angle_gains_q.kp <= cfg_data;
				REG_ANGLE_KI:       angle_gains_q.ki <= cfg_data;
				REG_ANGLE_KD:       angle_gains_q.kd <= cfg_data;
				REG_CART_KP:        cart_gains_q.kp  <= cfg_data;
				REG_CART_KI:        cart_gains_q.ki  <= cfg_data;
				REG_CART_KD:        cart_gains_q.kd  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage flow: each stage moves when the next is empty or moving
	assign move3o   = valid_s3 && (!m_valid_q || m_tready);
	assign move23   = valid_s2 && (!valid_s3 || move3o);
	assign move12   = valid_s1 && (!valid_s2 || move23);
	assign s_tready = !valid_s1 || move12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || move23)
				valid_s2 <= move12;
			if (!valid_s3 || move3o)
				valid_s3 <= move23;
			if (!m_valid_q || m_tready)
				m_valid_q <= move3o;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			angle_s1 <= s_tdata[SAMPLE_W-1:0];
			cart_s1  <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	assign swing = (aerr > SWING_THRESHOLD) || (aerr < -SWING_THRESHOLD);

	assign ctrl.move12 = move12;
	assign ctrl.move23 = move23;
	assign ctrl.swing  = swing;

	dpbc_lane u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.setpoint  (angle_sp_q),
		.sample_s1 (angle_s1),
		.gains     (angle_gains_q),
		.err       (aerr),
		.term_sum  (angle_term)
	);

	dpbc_lane u_cart (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.setpoint  (cart_sp_q),
		.sample_s1 (cart_s1),
		.gains     (cart_gains_q),
		.err       (cerr),
		.term_sum  (cart_term)
	);

	always_ff @(posedge clk) begin
		if (move12) begin
			aerr_s2  <= aerr;
			cerr_s2  <= cerr;
			swing_s2 <= swing;
		end
		if (move23) begin
			aerr_s3  <= aerr_s2;
			cerr_s3  <= cerr_s2;
			swing_s3 <= swing_s2;
		end
	end

	assign total = TOTAL_W'(angle_term) + TOTAL_W'(cart_term);

	always_comb begin
		if (swing_s3)
			drive_sat = '0;
		else if (total > TOTAL_W'(DRIVE_MAX))
			drive_sat = DRIVE_MAX;
		else if (total < TOTAL_W'(DRIVE_MIN))
			drive_sat = DRIVE_MIN;
		else
			drive_sat = total[DRIVE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (move3o) begin
			drive_q <= drive_sat;
			swing_q <= swing_s3;
			aerr_q  <= aerr_s3;
			cerr_q  <= cerr_s3;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = swing_q;
	assign m_tdata  = {{(OUT_DATA_W-DRIVE_W-2*ERR_W){1'b0}}, cerr_q, aerr_q, drive_q};

	a_swing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[DRIVE_W-1:0] == '0)
		else $error("swing-up result with nonzero drive");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	a_swing_flag: assert property (@(posedge clk) disable iff (!arst_n)
		move3o |-> swing_s3 == ((aerr_s3 > SWING_THRESHOLD) || (aerr_s3 < -SWING_THRESHOLD)))
		else $error("swing flag disagrees with angle error");

endmodule

// ----- sim/dual_pid_balance_controller_tb.sv -----
// ----------------------------------------------------------------------------
// dual_pid_balance_controller_tb
// Streams angle/cart samples through the controller under several gain and
// setpoint settings with random idling on both sides. A scoreboard predicts
// drive, swing-up flag and both errors per item, then checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_pid_balance_controller_tb;
	import dpbc_pkg::*;

	localparam int     CYCLE_LIMIT = 200000;
	localparam int     ITEMS_PER_PHASE = 150;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	localparam gains_t ANGLE_GAINS_DFLT = '{kp: ANGLE_KP_RST, ki: ANGLE_KI_RST, kd: ANGLE_KD_RST};
	localparam gains_t CART_GAINS_DFLT  = '{kp: CART_KP_RST, ki: CART_KI_RST, kd: CART_KD_RST};

	typedef enum int {
		GAINS_RESET, GAINS_WIDE, GAINS_NARROW, GAINS_EXTREME, GAINS_UNIT
	} gain_style_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      swing;
		logic signed [ERR_W-1:0]   angle_err;
		logic signed [ERR_W-1:0]   cart_dev;
	} pid_result_t;

	class pid_scoreboard;
		logic signed [SAMPLE_W-1:0] angle_sp;
		logic signed [SAMPLE_W-1:0] cart_sp;
		gains_t                     angle_gains;
		gains_t                     cart_gains;
		logic signed [SUM_W-1:0]    angle_sum;
		logic signed [SUM_W-1:0]    cart_sum;
		logic signed [ERR_W-1:0]    angle_prev;
		logic signed [ERR_W-1:0]    cart_prev;
		pid_result_t                expected_drive_q[$];
		int                         mismatches;

		function new();
			angle_sp    = '0;
			cart_sp     = '0;
			angle_gains = ANGLE_GAINS_DFLT;
			cart_gains  = CART_GAINS_DFLT;
			clear_loops();
			mismatches  = 0;
		endfunction

		function void clear_loops();
			angle_sum  = '0;
			cart_sum   = '0;
			angle_prev = '0;
			cart_prev  = '0;
		endfunction

		function int pending();
			return expected_drive_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ANGLE_SETPOINT: angle_sp = val[SAMPLE_W-1:0];
				REG_CART_SETPOINT:  cart_sp  = val[SAMPLE_W-1:0];
				REG_ANGLE_KP:       angle_gains.kp = val;
				REG_ANGLE_KI:       angle_gains.ki = val;
				REG_ANGLE_KD:       angle_gains.kd = val;
				REG_CART_KP:        cart_gains.kp  = val;
				REG_CART_KI:        cart_gains.ki  = val;
				REG_CART_KD:        cart_gains.kd  = val;
				default: ;
			endcase
		endfunction

		function longint sat_sum(longint v);
			if (v > SUM_MAX)
				return SUM_MAX;
			if (v < SUM_MIN)
				return SUM_MIN;
			return v;
		endfunction

		// Q12.20 gain times Q8.8 operand, floored back to Q8.8
		function longint scaled_term(logic signed [GAIN_W-1:0] g, longint x);
			return (longint'(g) * x) >>> FRAC_SH;
		endfunction

		function void predict_drive(logic [IN_DATA_W-1:0] d);
			int          ae;
			int          ce;
			longint      total;
			longint      s;
			pid_result_t r;
			ae = int'(angle_sp) - int'($signed(d[15:0]));
			ce = int'(cart_sp) - int'($signed(d[31:16]));
			r.angle_err = ae[ERR_W-1:0];
			r.cart_dev  = ce[ERR_W-1:0];
			r.swing = (ae > int'(SWING_THRESHOLD)) || (ae < -int'(SWING_THRESHOLD));
			if (r.swing) begin
				clear_loops();
				r.drive = '0;
			end else begin
				s = sat_sum(longint'(angle_sum) + longint'(ae));
				angle_sum = s[SUM_W-1:0];
				s = sat_sum(longint'(cart_sum) + longint'(ce));
				cart_sum = s[SUM_W-1:0];
				total = scaled_term(angle_gains.kp, longint'(ae))
				      + scaled_term(angle_gains.ki, longint'(angle_sum))
				      + scaled_term(angle_gains.kd, longint'(ae - int'(angle_prev)))
				      + scaled_term(cart_gains.kp, longint'(ce))
				      + scaled_term(cart_gains.ki, longint'(cart_sum))
				      + scaled_term(cart_gains.kd, longint'(ce - int'(cart_prev)));
				angle_prev = ae[ERR_W-1:0];
				cart_prev  = ce[ERR_W-1:0];
				if (total > longint'(DRIVE_MAX))
					r.drive = DRIVE_MAX;
				else if (total < longint'(DRIVE_MIN))
					r.drive = DRIVE_MIN;
				else
					r.drive = total[DRIVE_W-1:0];
			end
			expected_drive_q.push_back(r);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d, logic u);
			pid_result_t               e;
			logic signed [DRIVE_W-1:0] got_drive;
			logic signed [ERR_W-1:0]   got_aerr;
			logic signed [ERR_W-1:0]   got_cerr;
			got_drive = d[15:0];
			got_aerr  = d[32:16];
			got_cerr  = d[49:33];
			if (expected_drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no item pending: drive=%0d",
					         $realtime, got_drive);
				return;
			end
			e = expected_drive_q.pop_front();
			if (got_drive !== e.drive || u !== e.swing || got_aerr !== e.angle_err ||
			    got_cerr !== e.cart_dev || d[OUT_DATA_W-1:50] !== '0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch exp drive=%0d swing=%0d aerr=%0d cerr=%0d",
					          " got drive=%0d swing=%0d aerr=%0d cerr=%0d pad=%h"},
					         $realtime, e.drive, e.swing, e.angle_err, e.cart_dev,
					         got_drive, u, got_aerr, got_cerr, d[OUT_DATA_W-1:50]);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pid_scoreboard              sb;
	int                         tx_idle_pct;
	int                         rx_idle_pct;
	int                         cycle_count;
	logic signed [SAMPLE_W-1:0] cur_angle_sp;
	logic signed [SAMPLE_W-1:0] cur_cart_sp;

	dual_pid_balance_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dual_pid_balance_controller test failed");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// inputs only move at the rising edge, so the falling edge sees what the next edge takes
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.predict_drive(s_tdata);
		end
	end

	function automatic logic [SAMPLE_W-1:0] to_sample(int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [GAIN_W-1:0] pick_gain(gain_style_t st,
	                                                      logic signed [GAIN_W-1:0] dflt);
		case (st)
			GAINS_RESET:   return dflt;
			GAINS_WIDE:    return $urandom;
			GAINS_NARROW:  return int'($urandom_range(8388608)) - 4194304;
			GAINS_EXTREME: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default:       return int'($urandom_range(2097152)) - 1048576;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_setpoint(gain_style_t st);
		case (st)
			GAINS_WIDE:    return SAMPLE_W'($urandom);
			GAINS_EXTREME: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default:       return SAMPLE_W'(int'($urandom_range(8192)) - 4096);
		endcase
	endfunction

	// called at a rising edge; returns at the edge that took the item
	task automatic send_item(input logic [SAMPLE_W-1:0] angle, input logic [SAMPLE_W-1:0] cart);
		logic rdy;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {cart, angle};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic signed [SAMPLE_W-1:0] asp,
	                         input logic signed [SAMPLE_W-1:0] csp,
	                         input gains_t ag, input gains_t cg);
		drain();
		// junk above the setpoint width must be dropped
		cfg_write(REG_ANGLE_SETPOINT, {16'($urandom), asp});
		cfg_write(REG_CART_SETPOINT, {16'($urandom), csp});
		cfg_write(REG_ANGLE_KP, ag.kp);
		cfg_write(REG_ANGLE_KI, ag.ki);
		cfg_write(REG_ANGLE_KD, ag.kd);
		cfg_write(REG_CART_KP, cg.kp);
		cfg_write(REG_CART_KI, cg.ki);
		cfg_write(REG_CART_KD, cg.kd);
		cfg_valid <= 1'b0;
		cur_angle_sp = asp;
		cur_cart_sp  = csp;
	endtask

	task automatic run_phase(input gain_style_t st, input int n_items);
		gains_t ag;
		gains_t cg;
		int     err;
		int     sel;
		logic [SAMPLE_W-1:0] angle;
		logic [SAMPLE_W-1:0] cart;
		ag.kp = pick_gain(st, ANGLE_KP_RST);
		ag.ki = pick_gain(st, ANGLE_KI_RST);
		ag.kd = pick_gain(st, ANGLE_KD_RST);
		cg.kp = pick_gain(st, CART_KP_RST);
		cg.ki = pick_gain(st, CART_KI_RST);
		cg.kd = pick_gain(st, CART_KD_RST);
		configure(pick_setpoint(st), pick_setpoint(st), ag, cg);
		repeat (n_items) begin
			sel = $urandom_range(99);
			if (sel < 80) begin
				// mostly inside the balance window so the loops build up history
				if ($urandom_range(9) == 0)
					case ($urandom_range(4))
						0: err = int'(SWING_THRESHOLD);
						1: err = -int'(SWING_THRESHOLD);
						2: err = int'(SWING_THRESHOLD) + 1;
						3: err = -int'(SWING_THRESHOLD) - 1;
						default: err = 0;
					endcase
				else
					err = int'($urandom_range(2 * int'(SWING_THRESHOLD))) - int'(SWING_THRESHOLD);
				angle = to_sample(int'(cur_angle_sp) - err);
			end else begin
				angle = SAMPLE_W'($urandom);
			end
			if ($urandom_range(1))
				cart = SAMPLE_W'($urandom);
			else
				cart = to_sample(int'(cur_cart_sp) - (int'($urandom_range(1024)) - 512));
			send_item(angle, cart);
		end
	endtask

	initial begin
		sb          = new();
		cycle_count = 0;
		tx_idle_pct = 24;
		rx_idle_pct = 52;
		cur_angle_sp = '0;
		cur_cart_sp  = '0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_ANGLE_SETPOINT;
		cfg_data    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains, zero setpoints
		send_item(16'sd0, 16'sd0);
		send_item(-16'sd2560, 16'sd0);     // window edge, still balancing
		send_item(16'sd2560, 16'sd0);
		send_item(-16'sd2561, 16'sd100);   // just outside: swing-up
		send_item(16'sd2561, -16'sd100);
		send_item(-16'sd100, 16'sh7fff);
		send_item(-16'sd100, 16'sh8000);
		send_item(16'sh8000, 16'sd0);
		send_item(16'sh7fff, 16'sd0);
		send_item(16'sd5, 16'sd3);
		send_item(16'sd7, -16'sd3);
		send_item(-16'sd1, 16'sd1);
		send_item(16'sd1, -16'sd1);
		send_item(16'sd0, 16'sd0);

		// setpoints at opposite extremes give the widest errors
		configure(16'sh7fff, 16'sh8000, ANGLE_GAINS_DFLT, CART_GAINS_DFLT);
		send_item(16'sh8000, 16'sh7fff);
		send_item(16'sh7fff, 16'sh7fff);
		send_item(16'sd30207, 16'sh8000);
		send_item(16'sd30206, 16'sd0);
		configure(16'sh8000, 16'sh7fff, ANGLE_GAINS_DFLT, CART_GAINS_DFLT);
		send_item(16'sh7fff, 16'sh8000);
		send_item(16'sh8000, 16'sh8000);
		send_item(-16'sd30208, 16'sd0);

		run_phase(GAINS_RESET, ITEMS_PER_PHASE);
		run_phase(GAINS_WIDE, ITEMS_PER_PHASE);
		tx_idle_pct = 52;
		rx_idle_pct = 24;
		run_phase(GAINS_NARROW, ITEMS_PER_PHASE);
		run_phase(GAINS_EXTREME, ITEMS_PER_PHASE);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(GAINS_UNIT, ITEMS_PER_PHASE);
		run_phase(GAINS_RESET, ITEMS_PER_PHASE);

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("dual_pid_balance_controller test passed");
		else
			$display("dual_pid_balance_controller test failed");
		$finish;
	end

endmodule
